>>> src/fpcm_pkg.sv
// package for the float to pcm sample packer: payload structs, mode codes,
// register indexes and widths; no dependencies
`default_nettype none
package fpcm_pkg;

    localparam int SampleW = 32;
    localparam int BitsW   = 6;
    localparam int CountW  = 3;
    localparam int AddrW   = 5;

    typedef enum logic [2:0] {
        MODE_FLOAT  = 3'd0,
        MODE_INT16  = 3'd1,
        MODE_INT32  = 3'd2,
        MODE_INT24  = 3'd3,
        MODE_SILENT = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        REG_BITS    = 3'd0,
        REG_FLOAT   = 3'd1,
        REG_SIGNED  = 3'd2,
        REG_PACKED  = 3'd3,
        REG_ALIGN   = 3'd4,
        REG_BIG     = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [SampleW-1:0] sample_float;
        logic               end_of_block;
    } in_beat_t;

    typedef struct packed {
        logic [SampleW-1:0] out_word;
        logic [CountW-1:0]  byte_count;
        logic               last_out;
    } out_beat_t;

    typedef struct packed {
        mode_t mode;
        logic  align_high;
        logic  big_endian;
        logic  count_two;
    } ctrl_t;

endpackage
`default_nettype wire

>>> src/float_to_pcm_sample_packer_unit.sv
// top level of the float to pcm sample packer
// depends on fpcm_pkg, fpcm_regs, fpcm_pipe
`default_nettype none
// Converts one IEEE single-precision sample per beat into a device word
// (float passthrough, 16, 32 or 24-in-32 signed pcm, either byte order).
// A new beat is accepted every cycle while the output is not stalled; each
// result passes through the three-stage classify, shift and pack pipeline.
// Registers are written over the apb port and must change only while idle.
module float_to_pcm_sample_packer_unit (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  fpcm_pkg::in_beat_t           s_data,
    output logic                         m_valid,
    input  wire                          m_ready,
    output fpcm_pkg::out_beat_t          m_data,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [fpcm_pkg::AddrW-1:0]    paddr,
    input  wire [31:0]                   pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import fpcm_pkg::*;

    ctrl_t ctrl;
    assign pready = 1'b1;

    fpcm_regs u_regs (
        .aclk(aclk), .aresetn(aresetn), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .ctrl(ctrl)
    );

    fpcm_pipe u_pipe (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_valid), .in_ready(s_ready),
        .in_beat(s_data), .ctrl(ctrl), .out_valid(m_valid),
        .out_ready(m_ready), .out_beat(m_data)
    );
endmodule
`default_nettype wire

>>> src/fpcm_regs.sv
// apb register file for the packer; decodes the output mode
// depends on fpcm_pkg
`default_nettype none
module fpcm_regs (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [fpcm_pkg::AddrW-1:0]    paddr,
    input  wire [31:0]                   pwdata,
    output logic [31:0]                  prdata,
    output fpcm_pkg::ctrl_t              ctrl
);
    import fpcm_pkg::*;

    logic [BitsW-1:0] bits_reg;
    logic float_reg, signed_reg, packed_reg, align_reg, big_reg;
    logic wr;
    logic [2:0] idx;
    logic int_ok;

    assign wr  = psel & penable & pwrite;
    assign idx = paddr[AddrW-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_reg   <= BitsW'(16);
            float_reg  <= 1'b0;
            signed_reg <= 1'b1;
            packed_reg <= 1'b1;
            align_reg  <= 1'b0;
            big_reg    <= 1'b0;
        end else if (wr) begin
            case (idx)
                REG_BITS:   bits_reg   <= pwdata[BitsW-1:0];
                REG_FLOAT:  float_reg  <= pwdata[0];
                REG_SIGNED: signed_reg <= pwdata[0];
                REG_PACKED: packed_reg <= pwdata[0];
                REG_ALIGN:  align_reg  <= pwdata[0];
                REG_BIG:    big_reg    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_BITS:   prdata = {26'd0, bits_reg};
            REG_FLOAT:  prdata = {31'd0, float_reg};
            REG_SIGNED: prdata = {31'd0, signed_reg};
            REG_PACKED: prdata = {31'd0, packed_reg};
            REG_ALIGN:  prdata = {31'd0, align_reg};
            REG_BIG:    prdata = {31'd0, big_reg};
            default:    prdata = 32'd0;
        endcase
    end

    assign int_ok = !float_reg && signed_reg;

    always_comb begin
        if (float_reg && bits_reg == BitsW'(32))
            ctrl.mode = MODE_FLOAT;
        else if (int_ok && packed_reg && bits_reg == BitsW'(16))
            ctrl.mode = MODE_INT16;
        else if (int_ok && packed_reg && bits_reg == BitsW'(32))
            ctrl.mode = MODE_INT32;
        else if (int_ok && bits_reg == BitsW'(24))
            ctrl.mode = MODE_INT24;
        else
            ctrl.mode = MODE_SILENT;
        ctrl.align_high = align_reg;
        ctrl.big_endian = big_reg;
        ctrl.count_two  = (bits_reg == BitsW'(16));
    end
endmodule
`default_nettype wire

>>> src/fpcm_pipe.sv
// three-stage conversion pipeline: decode, shift to integer, saturate and pack
// depends on fpcm_pkg
`default_nettype none
module fpcm_pipe (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  fpcm_pkg::in_beat_t   in_beat,
    input  fpcm_pkg::ctrl_t      ctrl,
    output logic                 out_valid,
    input  wire                  out_ready,
    output fpcm_pkg::out_beat_t  out_beat
);
    import fpcm_pkg::*;

    // stage 1: classify
    logic        v1_reg;
    logic        sign1_reg, zero1_reg, sat1_reg;
    logic [4:0]  sh1_reg;
    logic [23:0] man1_reg;
    logic [31:0] raw1_reg;
    logic        last1_reg;
    ctrl_t       c1_reg;
    // stage 2: magnitude
    logic        v2_reg;
    logic        sign2_reg, sat2_reg;
    logic [31:0] mag2_reg;
    logic [31:0] raw2_reg;
    logic        last2_reg;
    ctrl_t       c2_reg;
    // stage 3: output
    logic        v3_reg;
    out_beat_t   o3_reg;

    logic adv1, adv2, adv3;
    assign adv3     = !v3_reg || out_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    logic [7:0]  e;
    logic [22:0] f;
    logic        nan, big;
    assign e   = in_beat.sample_float[30:23];
    assign f   = in_beat.sample_float[22:0];
    assign nan = (e == 8'hFF) && (f != 23'd0);
    // |x| >= 1 clamps to full scale
    assign big = (e >= 8'd127);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv1) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            sign1_reg <= in_beat.sample_float[31];
            zero1_reg <= nan || (e < 8'd96);
            sat1_reg  <= big && !nan;
            sh1_reg   <= 5'(8'd127 - e);
            man1_reg  <= {1'b1, f};
            raw1_reg  <= in_beat.sample_float;
            last1_reg <= in_beat.end_of_block;
            c1_reg    <= ctrl;
        end
    end

    // value * 2^31 = man * 2^(e-127+31-23); right shift by 127-e
    logic [55:0] wide;
    assign wide = {man1_reg, 32'd0} >> sh1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            sign2_reg <= sign1_reg;
            sat2_reg  <= sat1_reg;
            mag2_reg  <= zero1_reg ? 32'd0 : wide[55:24];
            raw2_reg  <= raw1_reg;
            last2_reg <= last1_reg;
            c2_reg    <= c1_reg;
        end
    end

    // mag2 is |x|*2^31 truncated, |x| < 1
    logic [31:0] q32, q16, q24, v, w;
    logic [31:0] m16, m24;
    assign m16 = {16'd0, mag2_reg[31:16]};
    assign m24 = {8'd0, mag2_reg[31:8]};

    always_comb begin
        if (sat2_reg) begin
            q32 = sign2_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            q16 = sign2_reg ? 32'h0000_8000 : 32'h0000_7FFF;
            q24 = sign2_reg ? 32'h0080_0000 : 32'h007F_FFFF;
        end else begin
            q32 = sign2_reg ? (~mag2_reg + 32'd1) : mag2_reg;
            q16 = {16'd0, 16'(sign2_reg ? (~m16 + 32'd1) : m16)};
            q24 = {8'd0, 24'(sign2_reg ? (~m24 + 32'd1) : m24)};
        end
        case (c2_reg.mode)
            MODE_FLOAT: v = raw2_reg;
            MODE_INT16: v = q16;
            MODE_INT32: v = q32;
            MODE_INT24: v = c2_reg.align_high ? {q24[23:0], 8'd0} : q24;
            default:    v = 32'd0;
        endcase
        if (!c2_reg.big_endian)
            w = v;
        else if (c2_reg.mode == MODE_INT16)
            w = {16'd0, v[7:0], v[15:8]};
        else
            w = {v[7:0], v[15:8], v[23:16], v[31:24]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv3) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv3) begin
            o3_reg.out_word <= w;
            o3_reg.byte_count <= ((c2_reg.mode == MODE_INT16) ||
                (c2_reg.mode == MODE_SILENT && c2_reg.count_two)) ? 3'd2 : 3'd4;
            o3_reg.last_out <= last2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_beat  = o3_reg;
endmodule
`default_nettype wire

>>> src/fpcm_checker.sv
// port-level checker for the packer, bound to the top level
// depends on fpcm_pkg
`default_nettype none
module fpcm_checker (
    input wire                 aclk,
    input wire                 aresetn,
    input wire                 s_ready,
    input wire                 m_valid,
    input wire                 m_ready,
    input fpcm_pkg::out_beat_t m_data
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.byte_count == 3'd2 || m_data.byte_count == 3'd4))
        else $error("bad byte count");
    a_upper: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.byte_count == 3'd2 |-> m_data.out_word[31:16] == 16'd0)
        else $error("upper bytes not zero");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");
endmodule

bind float_to_pcm_sample_packer_unit fpcm_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
`default_nettype wire
